### hdl/nfb_pkg.sv
`timescale 1ns / 1ps
package nfb_pkg;
  localparam int MAX_INPUTS_DEF = 64;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int ACC_W = 40;

  localparam logic [2:0] REQ_LOAD = 3'd0;
  localparam logic [2:0] REQ_FWD  = 3'd1;
  localparam logic [2:0] REQ_OBP  = 3'd2;
  localparam logic [2:0] REQ_HBP  = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;

  localparam logic [1:0] KIND_FWD   = 2'd0;
  localparam logic [1:0] KIND_DELTA = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_LR    = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic [1:0] ACT_SOFTSIGN = 2'd0;
  localparam logic [1:0] ACT_TANH     = 2'd1;
  localparam logic [1:0] ACT_RELU     = 2'd2;

  function automatic logic [12:0] tanh_tab(input logic [4:0] k);
    logic [12:0] r;
    begin
      unique case (k)
        5'd0: r = 13'd0;     5'd1: r = 13'd1003;  5'd2: r = 13'd1893;
        5'd3: r = 13'd2602;  5'd4: r = 13'd3119;  5'd5: r = 13'd3475;
        5'd6: r = 13'd3707;  5'd7: r = 13'd3856;  5'd8: r = 13'd3949;
        5'd9: r = 13'd4006;  5'd10: r = 13'd4041; 5'd11: r = 13'd4063;
        5'd12: r = 13'd4076; 5'd13: r = 13'd4084; 5'd14: r = 13'd4089;
        5'd15: r = 13'd4091; default: r = 13'd4093;
      endcase
      return r;
    end
  endfunction
endpackage

### hdl/nfb_if.sv
`timescale 1ns / 1ps
interface nfb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [6:0]  index;
  logic signed [15:0] value;
  logic signed [15:0] partner_weight;
  logic        last;
  modport source (output valid, req_type, index, value, partner_weight, last, input ready);
  modport sink (input valid, req_type, index, value, partner_weight, last, output ready);
endinterface

interface nfb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [15:0] result_value;
  modport source (output valid, kind, result_value, input ready);
  modport sink (input valid, kind, result_value, output ready);
endinterface

interface nfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/nfb_div.sv
`timescale 1ns / 1ps
// Restoring divider for softsign: q = floor(a*4096 / (4096+a)), a nonnegative.
module nfb_div
  import nfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] a,
  output logic        done,
  output logic [12:0] q
);
  logic [28:0] num_r, num_nxt;
  logic [29:0] rem_r, rem_nxt;
  logic [16:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [29:0] trial;

  always_comb begin
    trial = {rem_r[28:0], num_r[28]};
    if (trial >= {13'd0, den_r}) begin
      rem_nxt = trial - {13'd0, den_r};
      num_nxt = {num_r[27:0], 1'b1};
    end else begin
      rem_nxt = trial;
      num_nxt = {num_r[27:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd28;
        num_r  <= {1'b0, a, 12'd0};
        rem_r  <= '0;
        den_r  <= 17'd4096 + {1'b0, a};
      end else if (busy_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end
  assign q = num_r[12:0];
endmodule

### hdl/neuron_forward_backprop.sv
`timescale 1ns / 1ps
// One trainable neuron in Q4.12. Weights and inputs live in a synchronous
// memory of MAX_INPUTS words each; one word is handled at a time. A load is
// written as it is taken. A forward input that does not close a stream is
// accepted, read and multiply-accumulated; one at or beyond the count is
// neither stored nor accumulated. A closing forward word then forms the sum
// and the activation, under softsign by way of a 29-step serial divider. An
// output backward word, or a hidden one that closes its stream, forms the
// delta, then walks the weight memory, reading, scaling and writing each weight
// in use, and updates the bias before the delta is sent. A weight readback is
// offered once its word has been read from memory, a bias readback in the cycle
// after its word is taken. Each result waits in an output register, and no
// new word is taken until it has left. Memories need no clearing after reset.
module neuron_forward_backprop
  import nfb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  nfb_in_if.sink   in_ch,
  nfb_out_if.source out_ch,
  nfb_cfg_if.sink  cfg_ch
);
  localparam int MAX_INPUTS = MAX_INPUTS_DEF;
  localparam int DATA_WIDTH = DATA_WIDTH_DEF;
  localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam logic signed [47:0] DMAX = (48'sd1 <<< (DATA_WIDTH - 1)) - 48'sd1;
  localparam logic signed [47:0] DMIN = -DMAX - 48'sd1;
  localparam logic signed [47:0] AMAX = (48'sd1 <<< 39) - 48'sd1;
  localparam logic signed [47:0] AMIN = -AMAX - 48'sd1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_MAC, S_CLOSE, S_ACT, S_DIVW, S_ACTT, S_EMIT,
    S_BP, S_DER, S_DER2, S_DELTA, S_DELTA2, S_UP_RD, S_UP_G, S_UP_S, S_UP_W,
    S_BIAS, S_BIAS2
  } state_t;

  function automatic logic signed [47:0] sat_d(input logic signed [63:0] v);
    if (v > 64'(DMAX)) return DMAX;
    if (v < 64'(DMIN)) return DMIN;
    return 48'(v);
  endfunction
  function automatic logic signed [47:0] sat_a(input logic signed [63:0] v);
    if (v > 64'(AMAX)) return AMAX;
    if (v < 64'(AMIN)) return AMIN;
    return 48'(v);
  endfunction

  state_t state_r;
  logic [1:0]  mode_r;
  logic [15:0] lr_r;
  logic [6:0]  count_r;

  logic signed [DATA_WIDTH-1:0] wmem [MAX_INPUTS];
  logic signed [DATA_WIDTH-1:0] imem [MAX_INPUTS];
  logic signed [DATA_WIDTH-1:0] wrd_r, ird_r;

  logic [2:0]  req_r;
  logic [6:0]  idx_r;
  logic signed [15:0] val_r, par_r;
  logic        last_r;
  logic [AW:0] ptr_r;
  logic signed [DATA_WIDTH-1:0] bias_r, ssum_r, sout_r, delta_r;
  logic signed [47:0] acc_r, err_r, t_r;
  logic signed [63:0] prod_r;
  logic signed [15:0] der_r;
  logic signed [15:0] f_r;

  logic ov_r;
  logic [1:0] okind_r;
  logic signed [15:0] oval_r;

  logic div_start, div_done;
  logic [12:0] div_q;
  logic [15:0] abs_s;

  nfb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(abs_s),
    .done(div_done), .q(div_q)
  );

  logic [6:0] used;
  assign used = (32'(count_r) < MAX_INPUTS) ? count_r : 7'(MAX_INPUTS);
  assign abs_s = ssum_r[DATA_WIDTH-1] ? 16'(-32'(ssum_r)) : 16'(32'(ssum_r));

  assign in_ch.ready  = (state_r == S_IDLE) && !ov_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.kind  = okind_r;
  assign out_ch.result_value = oval_r;
  assign div_start = ((state_r == S_ACT) || (state_r == S_DER)) && (mode_r == ACT_SOFTSIGN);

  // tanh of the stored sum, combinational from the table.
  logic signed [31:0] tanh_v;
  always_comb begin
    logic [4:0] seg;
    logic [12:0] lo, hi;
    logic signed [31:0] y;
    seg = (abs_s[15:10] >= 6'd16) ? 5'd16 : abs_s[14:10];
    lo = tanh_tab(seg);
    hi = tanh_tab((seg == 5'd16) ? 5'd16 : seg + 5'd1);
    if (seg == 5'd16) y = 32'(lo);
    else y = 32'(lo) + (((32'(hi) - 32'(lo)) * 32'(abs_s[9:0]) + 32'sd512) >>> 10);
    tanh_v = ssum_r[DATA_WIDTH-1] ? -y : y;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD || state_r == S_UP_RD) begin
      wrd_r <= wmem[ptr_r[AW-1:0]];
      ird_r <= imem[ptr_r[AW-1:0]];
    end
    if (state_r == S_IDLE && in_ch.valid && in_ch.ready) begin
      if (in_ch.req_type == REQ_LOAD && 32'(in_ch.index) < MAX_INPUTS)
        wmem[in_ch.index[AW-1:0]] <= DATA_WIDTH'(sat_d(64'(in_ch.value)));
      if (in_ch.req_type == REQ_FWD && in_ch.index < used)
        imem[in_ch.index[AW-1:0]] <= DATA_WIDTH'(sat_d(64'(in_ch.value)));
    end
    if (state_r == S_UP_W)
      wmem[ptr_r[AW-1:0]] <= DATA_WIDTH'(sat_d(64'(wrd_r) - 64'(t_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= '0; lr_r <= 16'd655; count_r <= 7'd64;
      bias_r <= '0; acc_r <= '0; err_r <= '0; ssum_r <= '0; sout_r <= '0;
      ov_r <= 1'b0; okind_r <= KIND_FWD;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_MODE:  mode_r <= cfg_ch.data[1:0];
          CFG_LR:    lr_r <= cfg_ch.data;
          CFG_COUNT: count_r <= cfg_ch.data[6:0];
          default: ;
        endcase
      end
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          req_r <= in_ch.req_type; idx_r <= in_ch.index;
          val_r <= in_ch.value; par_r <= in_ch.partner_weight;
          last_r <= in_ch.last;
          ptr_r <= in_ch.index[AW:0];
          unique case (in_ch.req_type)
            REQ_LOAD:
              if (32'(in_ch.index) == MAX_INPUTS)
                bias_r <= DATA_WIDTH'(sat_d(64'(in_ch.value)));
            REQ_FWD:
              if (in_ch.index < used) state_r <= S_RD;
              else if (in_ch.last) state_r <= S_CLOSE;
            REQ_OBP: state_r <= S_BP;
            REQ_HBP: begin
              err_r <= sat_a(64'(err_r) + 64'(in_ch.value) * 64'(in_ch.partner_weight));
              if (in_ch.last) state_r <= S_BP;
            end
            REQ_READ:
              if (32'(in_ch.index) < MAX_INPUTS) state_r <= S_RD;
              else begin
                ov_r <= 1'b1; okind_r <= KIND_READ;
                oval_r <= (32'(in_ch.index) == MAX_INPUTS) ? 16'(bias_r) : 16'd0;
              end
            default: ;
          endcase
        end
        S_RD: state_r <= S_MAC;
        S_MAC: begin
          if (req_r == REQ_READ) begin
            ov_r <= 1'b1; okind_r <= KIND_READ; oval_r <= 16'(wrd_r);
            state_r <= S_IDLE;
          end else begin
            acc_r <= sat_a(64'(acc_r) + 64'(wrd_r) * 64'(ird_r));
            state_r <= last_r ? S_CLOSE : S_IDLE;
          end
        end
        S_CLOSE: begin
          ssum_r <= DATA_WIDTH'(sat_d((64'(acc_r) + (64'(bias_r) <<< 12) + 64'sd2048)
                                     >>> 12));
          acc_r <= '0;
          state_r <= S_ACT;
        end
        S_ACT: state_r <= (mode_r == ACT_SOFTSIGN) ? S_DIVW : S_ACTT;
        S_DIVW: if (div_done) begin
          f_r <= ssum_r[DATA_WIDTH-1] ? -16'(div_q) : 16'(div_q);
          state_r <= (req_r == REQ_FWD) ? S_ACTT : S_DER2;
        end
        S_ACTT: begin
          unique case (mode_r)
            ACT_SOFTSIGN: sout_r <= DATA_WIDTH'(f_r);
            ACT_TANH:     sout_r <= DATA_WIDTH'(tanh_v);
            ACT_RELU:     sout_r <= ssum_r[DATA_WIDTH-1] ? '0 : ssum_r;
            default:      sout_r <= '0;
          endcase
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          ov_r <= 1'b1; okind_r <= KIND_FWD; oval_r <= 16'(sout_r);
          state_r <= S_IDLE;
        end
        S_BP: begin
          if (32'(ssum_r) >= 32'sd8192) ssum_r <= DATA_WIDTH'(8191);
          else if (32'(ssum_r) <= -32'sd8192) ssum_r <= DATA_WIDTH'(-8191);
          state_r <= S_DER;
        end
        S_DER: begin
          if (mode_r == ACT_SOFTSIGN) state_r <= S_DIVW;
          else begin
            f_r <= 16'(tanh_v);
            state_r <= S_DER2;
          end
        end
        S_DER2: begin
          unique case (mode_r)
            ACT_SOFTSIGN:
              der_r <= 16'((32'(f_r) * (32'sd4096 - 32'(f_r)) + 32'sd2048) >>> 12);
            ACT_TANH: der_r <= 16'(32'sd4096 - ((32'(f_r) * 32'(f_r) + 32'sd2048) >>> 12));
            ACT_RELU: der_r <= ssum_r[DATA_WIDTH-1] ? 16'sd0 : 16'sd4096;
            default:  der_r <= 16'sd0;
          endcase
          state_r <= S_DELTA;
        end
        S_DELTA: begin
          if (req_r == REQ_OBP)
            prod_r <= (64'(sout_r) - 64'(val_r)) * 64'(der_r);
          else prod_r <= 64'(err_r) * 64'(der_r);
          state_r <= S_DELTA2;
        end
        S_DELTA2: begin
          if (req_r == REQ_OBP)
            delta_r <= DATA_WIDTH'(sat_d((64'(prod_r) + 64'sd2048) >>> 12));
          else begin
            delta_r <= DATA_WIDTH'(sat_d((64'(prod_r) + 64'sd8388608) >>> 24));
            err_r <= '0;
          end
          ptr_r <= '0;
          state_r <= (used == 7'd0) ? S_BIAS : S_UP_RD;
        end
        S_UP_RD: state_r <= S_UP_G;
        S_UP_G: begin
          t_r <= sat_d((64'(delta_r) * 64'(ird_r) + 64'sd2048) >>> 12);
          state_r <= S_UP_S;
        end
        S_UP_S: begin
          t_r <= 48'((64'(t_r) * 64'(lr_r) + 64'sd32768) >>> 16);
          state_r <= S_UP_W;
        end
        S_UP_W: begin
          ptr_r <= ptr_r + 1'b1;
          state_r <= (7'(ptr_r) + 7'd1 >= used) ? S_BIAS : S_UP_RD;
        end
        S_BIAS: begin
          t_r <= 48'((64'(delta_r) * 64'(lr_r) + 64'sd32768) >>> 16);
          state_r <= S_BIAS2;
        end
        S_BIAS2: begin
          bias_r <= DATA_WIDTH'(sat_d(64'(bias_r) - 64'(t_r)));
          ov_r <= 1'b1; okind_r <= KIND_DELTA; oval_r <= 16'(delta_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == S_IDLE)) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r && $stable(oval_r)) else $error("word dropped");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP_W) |-> (7'(ptr_r) < used)) else $error("walk out of range");
endmodule
